// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("check failed");

// Condition that must never be seen.
`define ASSERT_NEVER(name, cond) \
  `ASSERT_CLK(name, !(cond))

`endif

// ===== src/ykf_pkg.sv =====
package ykf_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RegW    = 31;
  localparam int unsigned NumTmp  = 11;
  localparam int unsigned TmpAw   = 4;
  localparam int unsigned PcW     = 7;
  localparam int unsigned DivSteps = 47;
  localparam int unsigned DivCntW = 6;

  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] OneV   = ValW'(1) << FracW;
  localparam logic [ValW-1:0] HalfV  = ValW'(1) << (FracW - 1);
  localparam logic [ValW-1:0] TenV   = ValW'(10) << FracW;
  localparam logic [RegW-1:0] RegRst = RegW'(65536);

  localparam logic [1:0] RegProc  = 2'd0;
  localparam logic [1:0] RegWheel = 2'd1;
  localparam logic [1:0] RegGyro  = 2'd2;

  localparam logic [PcW-1:0] PcPredict = PcW'(0);
  localparam logic [PcW-1:0] PcUpdate  = PcW'(22);
  localparam logic [PcW-1:0] PcInit    = PcW'(78);

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_MEAN, OP_CHK, OP_END
  } op_e;

  typedef enum logic [4:0] {
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9, S_T10,
    S_RATE, S_ACC, S_P00, S_P01, S_P11,
    S_DT, S_ZW, S_ZG, S_ZERO, S_TEN, S_HALF, S_ONE, S_Q, S_R1, S_R2
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIVW, ST_WB, ST_DONE
  } st_e;

  typedef struct packed {
    op_e  op;
    src_e dst;
    src_e a;
    src_e b;
  } uop_t;

  function automatic uop_t mk(input op_e op, input src_e d, input src_e a, input src_e b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  // Micro-program: predict at 0, update at 22, first update at 78.
  function automatic uop_t rom(input logic [PcW-1:0] pc);
    uop_t u;
    u = mk(OP_END, S_T0, S_ZERO, S_ZERO);
    case (pc)
      7'd0:  u = mk(OP_MUL, S_T0, S_DT, S_DT);
      7'd1:  u = mk(OP_MUL, S_T1, S_T0, S_HALF);
      7'd2:  u = mk(OP_MUL, S_T2, S_DT, S_ACC);
      7'd3:  u = mk(OP_MUL, S_T3, S_DT, S_P01);
      7'd4:  u = mk(OP_ADD, S_T4, S_P00, S_T3);
      7'd5:  u = mk(OP_ADD, S_T4, S_T4, S_T3);
      7'd6:  u = mk(OP_MUL, S_T5, S_T0, S_P11);
      7'd7:  u = mk(OP_ADD, S_T4, S_T4, S_T5);
      7'd8:  u = mk(OP_MUL, S_T5, S_T1, S_T1);
      7'd9:  u = mk(OP_MUL, S_T5, S_T5, S_Q);
      7'd10: u = mk(OP_ADD, S_T4, S_T4, S_T5);
      7'd11: u = mk(OP_MUL, S_T5, S_DT, S_P11);
      7'd12: u = mk(OP_ADD, S_T6, S_P01, S_T5);
      7'd13: u = mk(OP_MUL, S_T5, S_T1, S_DT);
      7'd14: u = mk(OP_MUL, S_T5, S_T5, S_Q);
      7'd15: u = mk(OP_ADD, S_T6, S_T6, S_T5);
      7'd16: u = mk(OP_MUL, S_T5, S_T0, S_Q);
      7'd17: u = mk(OP_ADD, S_P11, S_P11, S_T5);
      7'd18: u = mk(OP_ADD, S_P01, S_T6, S_ZERO);
      7'd19: u = mk(OP_ADD, S_P00, S_T4, S_ZERO);
      7'd20: u = mk(OP_ADD, S_RATE, S_RATE, S_T2);
      7'd21: u = mk(OP_END, S_T0, S_ZERO, S_ZERO);
      7'd22: u = mk(OP_ADD, S_T0, S_R1, S_R2);
      7'd23: u = mk(OP_MUL, S_T0, S_P00, S_T0);
      7'd24: u = mk(OP_MUL, S_T1, S_R1, S_R2);
      7'd25: u = mk(OP_ADD, S_T0, S_T0, S_T1);
      7'd26: u = mk(OP_CHK, S_T0, S_T0, S_ZERO);
      7'd27: u = mk(OP_DIV, S_T1, S_R1, S_T0);
      7'd28: u = mk(OP_DIV, S_T2, S_R2, S_T0);
      7'd29: u = mk(OP_MUL, S_T3, S_P00, S_T2);
      7'd30: u = mk(OP_MUL, S_T4, S_P00, S_T1);
      7'd31: u = mk(OP_MUL, S_T5, S_P01, S_T2);
      7'd32: u = mk(OP_MUL, S_T6, S_P01, S_T1);
      7'd33: u = mk(OP_SUB, S_T7, S_ZW, S_RATE);
      7'd34: u = mk(OP_SUB, S_T8, S_ZG, S_RATE);
      7'd35: u = mk(OP_MUL, S_T9, S_T3, S_T7);
      7'd36: u = mk(OP_ADD, S_T9, S_RATE, S_T9);
      7'd37: u = mk(OP_MUL, S_T10, S_T4, S_T8);
      7'd38: u = mk(OP_ADD, S_RATE, S_T9, S_T10);
      7'd39: u = mk(OP_MUL, S_T9, S_T5, S_T7);
      7'd40: u = mk(OP_ADD, S_T9, S_ACC, S_T9);
      7'd41: u = mk(OP_MUL, S_T10, S_T6, S_T8);
      7'd42: u = mk(OP_ADD, S_ACC, S_T9, S_T10);
      7'd43: u = mk(OP_ADD, S_T0, S_T3, S_T4);
      7'd44: u = mk(OP_ADD, S_T1, S_T5, S_T6);
      7'd45: u = mk(OP_SUB, S_T2, S_ONE, S_T0);
      7'd46: u = mk(OP_MUL, S_T7, S_T2, S_T2);
      7'd47: u = mk(OP_MUL, S_T7, S_T7, S_P00);
      7'd48: u = mk(OP_MUL, S_T8, S_T3, S_T3);
      7'd49: u = mk(OP_MUL, S_T8, S_T8, S_R1);
      7'd50: u = mk(OP_ADD, S_T7, S_T7, S_T8);
      7'd51: u = mk(OP_MUL, S_T8, S_T4, S_T4);
      7'd52: u = mk(OP_MUL, S_T8, S_T8, S_R2);
      7'd53: u = mk(OP_ADD, S_T7, S_T7, S_T8);
      7'd54: u = mk(OP_MUL, S_T8, S_T1, S_P00);
      7'd55: u = mk(OP_SUB, S_T8, S_P01, S_T8);
      7'd56: u = mk(OP_MUL, S_T8, S_T2, S_T8);
      7'd57: u = mk(OP_MUL, S_T9, S_T3, S_T5);
      7'd58: u = mk(OP_MUL, S_T9, S_T9, S_R1);
      7'd59: u = mk(OP_ADD, S_T8, S_T8, S_T9);
      7'd60: u = mk(OP_MUL, S_T9, S_T4, S_T6);
      7'd61: u = mk(OP_MUL, S_T9, S_T9, S_R2);
      7'd62: u = mk(OP_ADD, S_T8, S_T8, S_T9);
      7'd63: u = mk(OP_MUL, S_T9, S_T1, S_P01);
      7'd64: u = mk(OP_MUL, S_T10, S_T1, S_T1);
      7'd65: u = mk(OP_MUL, S_T10, S_T10, S_P00);
      7'd66: u = mk(OP_SUB, S_T10, S_T10, S_T9);
      7'd67: u = mk(OP_SUB, S_T10, S_T10, S_T9);
      7'd68: u = mk(OP_ADD, S_T10, S_T10, S_P11);
      7'd69: u = mk(OP_MUL, S_T9, S_T5, S_T5);
      7'd70: u = mk(OP_MUL, S_T9, S_T9, S_R1);
      7'd71: u = mk(OP_ADD, S_T10, S_T10, S_T9);
      7'd72: u = mk(OP_MUL, S_T9, S_T6, S_T6);
      7'd73: u = mk(OP_MUL, S_T9, S_T9, S_R2);
      7'd74: u = mk(OP_ADD, S_P11, S_T10, S_T9);
      7'd75: u = mk(OP_ADD, S_P01, S_T8, S_ZERO);
      7'd76: u = mk(OP_ADD, S_P00, S_T7, S_ZERO);
      7'd77: u = mk(OP_END, S_T0, S_ZERO, S_ZERO);
      7'd78: u = mk(OP_MEAN, S_RATE, S_ZW, S_ZG);
      7'd79: u = mk(OP_ADD, S_ACC, S_ZERO, S_ZERO);
      7'd80: u = mk(OP_ADD, S_P00, S_ONE, S_ZERO);
      7'd81: u = mk(OP_ADD, S_P01, S_ZERO, S_ZERO);
      7'd82: u = mk(OP_ADD, S_P11, S_TEN, S_ZERO);
      default: u = mk(OP_END, S_T0, S_ZERO, S_ZERO);
    endcase
    return u;
  endfunction

endpackage

// ===== src/ykf_mul.sv =====
module ykf_mul (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ykf_pkg::ValW-1:0]  a_i,
  input  logic [ykf_pkg::ValW-1:0]  b_i,
  output logic [ykf_pkg::ValW-1:0]  res_o
);

  logic                          neg_q;
  logic [2*ykf_pkg::ValW-1:0]    prod_q;
  logic [ykf_pkg::ValW-1:0]      ma, mb;
  logic [2*ykf_pkg::ValW:0]      rnd;
  logic [2*ykf_pkg::ValW-ykf_pkg::FracW:0] mg;
  logic [ykf_pkg::ValW-1:0]      lim;

  assign ma = a_i[ykf_pkg::ValW-1] ? (~a_i + 1'b1) : a_i;
  assign mb = b_i[ykf_pkg::ValW-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ma * mb;
      neg_q  <= a_i[ykf_pkg::ValW-1] ^ b_i[ykf_pkg::ValW-1];
    end
  end

  // round to nearest, ties away from zero, then saturate
  always_comb begin
    rnd = {1'b0, prod_q} + (2*ykf_pkg::ValW+1)'(ykf_pkg::HalfV);
    mg  = rnd[2*ykf_pkg::ValW:ykf_pkg::FracW];
    lim = neg_q ? ykf_pkg::ValMin : ykf_pkg::ValMax;
    if (mg > (2*ykf_pkg::ValW-ykf_pkg::FracW+1)'(lim)) begin
      res_o = neg_q ? ykf_pkg::ValMin : ykf_pkg::ValMax;
    end else if (neg_q) begin
      res_o = ~mg[ykf_pkg::ValW-1:0] + 1'b1;
    end else begin
      res_o = mg[ykf_pkg::ValW-1:0];
    end
  end

endmodule

// ===== src/ykf_div.sv =====
`include "assert_macros.svh"

module ykf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ykf_pkg::RegW-1:0]  num_i,
  input  logic [ykf_pkg::ValW-1:0]  den_i,
  output logic                      done_o,
  output logic [ykf_pkg::ValW-1:0]  quo_o
);

  localparam int unsigned DvdW = ykf_pkg::RegW + ykf_pkg::FracW;

  logic                         busy_q, done_q;
  logic [ykf_pkg::DivCntW-1:0]  cnt_q;
  logic [DvdW-1:0]              dvd_q;
  logic [ykf_pkg::ValW:0]       rem_q, rem_sh;
  logic [DvdW:0]                quo_q;
  logic [ykf_pkg::ValW-1:0]     den_q;
  logic                         ge, rnd;
  logic [DvdW+1:0]              qr;

  assign rem_sh = {rem_q[ykf_pkg::ValW-1:0], dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ykf_pkg::DivCntW'(ykf_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ykf_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {ykf_pkg::FracW{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[DvdW-1:0], ge};
    end
  end

  always_comb begin
    rnd = {rem_q, 1'b0} >= {2'b0, den_q};
    qr  = {1'b0, quo_q} + (DvdW+2)'(rnd);
    if (qr > (DvdW+2)'(ykf_pkg::ValMax)) begin
      quo_o = ykf_pkg::ValMax;
    end else begin
      quo_o = qr[ykf_pkg::ValW-1:0];
    end
  end

  assign done_o = done_q;

  `ASSERT_CLK(a_div_start_busy, start_i |=> busy_q)
  `ASSERT_NEVER(a_div_done_while_busy, done_q && busy_q)

endmodule

// ===== src/yaw_rate_kalman_fusion_unit.sv =====
// Two-state yaw-rate Kalman filter (rate, angular acceleration) in Q16.16 with
// saturation. One item is taken at a time: s_axis_tready is high only while the
// unit is idle. Every update, and every predict after the first update, runs a
// micro-program over one shared multiplier, one saturating adder and a
// bit-serial divider; each micro-op goes through operand read, execute and
// write-back, and a divide waits on the divider before write-back. A predict
// before the first update runs no micro-program. The result sits in an output
// register, so the next request can be taken while it waits on m_axis_tready.
`include "assert_macros.svh"

module yaw_rate_kalman_fusion_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // time_step[15:0], wheel_rate[47:16], gyro_rate[79:48]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // rate_estimate[31:0], accel_estimate[63:32],
                                     // rate_variance[94:64], ready_res[95]
);

  localparam int unsigned W = ykf_pkg::ValW;

  ykf_pkg::st_e st_q, st_d;
  logic [ykf_pkg::PcW-1:0] pc_q;
  ykf_pkg::uop_t uop;

  logic [ykf_pkg::RegW-1:0] qv_q, r1_q, r2_q;
  logic [W-1:0] rate_q, acc_q, p00_q, p01_q, p11_q;
  logic [W-1:0] dt_q, zw_q, zg_q;
  logic         started_q;

  logic [W-1:0] tmp_mem [ykf_pkg::NumTmp];
  logic [W-1:0] rd_a_q, rd_b_q;
  logic [W-1:0] opa, opb, res_q, wb_val, mul_res, div_res;
  logic [W:0]   sum, dif, msum;
  logic         div_done, div_start, mul_en, wb_en, accept, out_load;

  logic         m_valid_q;
  logic [95:0]  m_data_q;

  assign uop    = ykf_pkg::rom(pc_q);
  assign accept = s_axis_tvalid && s_axis_tready;

  function automatic logic [W-1:0] pick(input ykf_pkg::src_e s, input logic [W-1:0] mem_v,
                                        input logic [W-1:0] rate, input logic [W-1:0] acc,
                                        input logic [W-1:0] p00, input logic [W-1:0] p01,
                                        input logic [W-1:0] p11, input logic [W-1:0] dt,
                                        input logic [W-1:0] zw, input logic [W-1:0] zg,
                                        input logic [W-1:0] qv, input logic [W-1:0] r1,
                                        input logic [W-1:0] r2);
    logic [W-1:0] v;
    unique case (s)
      ykf_pkg::S_RATE: v = rate;
      ykf_pkg::S_ACC:  v = acc;
      ykf_pkg::S_P00:  v = p00;
      ykf_pkg::S_P01:  v = p01;
      ykf_pkg::S_P11:  v = p11;
      ykf_pkg::S_DT:   v = dt;
      ykf_pkg::S_ZW:   v = zw;
      ykf_pkg::S_ZG:   v = zg;
      ykf_pkg::S_ZERO: v = '0;
      ykf_pkg::S_TEN:  v = ykf_pkg::TenV;
      ykf_pkg::S_HALF: v = ykf_pkg::HalfV;
      ykf_pkg::S_ONE:  v = ykf_pkg::OneV;
      ykf_pkg::S_Q:    v = qv;
      ykf_pkg::S_R1:   v = r1;
      ykf_pkg::S_R2:   v = r2;
      default:         v = mem_v;
    endcase
    return v;
  endfunction

  function automatic logic [W-1:0] sat33(input logic [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? ykf_pkg::ValMin : ykf_pkg::ValMax;
    end
    return s[W-1:0];
  endfunction

  assign opa = pick(uop.a, rd_a_q, rate_q, acc_q, p00_q, p01_q, p11_q, dt_q, zw_q, zg_q,
                    W'(qv_q), W'(r1_q), W'(r2_q));
  assign opb = pick(uop.b, rd_b_q, rate_q, acc_q, p00_q, p01_q, p11_q, dt_q, zw_q, zg_q,
                    W'(qv_q), W'(r1_q), W'(r2_q));

  assign sum  = {opa[W-1], opa} + {opb[W-1], opb};
  assign dif  = {opa[W-1], opa} - {opb[W-1], opb};
  assign msum = sum >>> 1;

  ykf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (mul_res)
  );

  ykf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa[ykf_pkg::RegW-1:0]),
    .den_i   (opb),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ykf_pkg::ST_IDLE: begin
        if (accept) begin
          st_d = (s_axis_tuser || started_q) ? ykf_pkg::ST_READ : ykf_pkg::ST_DONE;
        end
      end
      ykf_pkg::ST_READ: st_d = ykf_pkg::ST_EXEC;
      ykf_pkg::ST_EXEC: begin
        unique case (uop.op)
          ykf_pkg::OP_END: st_d = ykf_pkg::ST_DONE;
          ykf_pkg::OP_DIV: st_d = ykf_pkg::ST_DIVW;
          ykf_pkg::OP_CHK: st_d = opa[W-1] || (opa == '0) ? ykf_pkg::ST_DONE : ykf_pkg::ST_WB;
          default:         st_d = ykf_pkg::ST_WB;
        endcase
      end
      ykf_pkg::ST_DIVW: begin
        if (div_done) begin
          st_d = ykf_pkg::ST_WB;
        end
      end
      ykf_pkg::ST_WB:   st_d = ykf_pkg::ST_READ;
      ykf_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          st_d = ykf_pkg::ST_IDLE;
        end
      end
      default: st_d = ykf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (st_q == ykf_pkg::ST_IDLE);
    mul_en    = (st_q == ykf_pkg::ST_EXEC) && (uop.op == ykf_pkg::OP_MUL);
    div_start = (st_q == ykf_pkg::ST_EXEC) && (uop.op == ykf_pkg::OP_DIV);
    wb_en     = (st_q == ykf_pkg::ST_WB) && (uop.op != ykf_pkg::OP_CHK);
    out_load  = (st_q == ykf_pkg::ST_DONE) && (!m_valid_q || m_axis_tready);
    wb_val    = (uop.op == ykf_pkg::OP_MUL) ? mul_res : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ykf_pkg::ST_IDLE;
      pc_q      <= '0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
      qv_q      <= ykf_pkg::RegRst;
      r1_q      <= ykf_pkg::RegRst;
      r2_q      <= ykf_pkg::RegRst;
      rate_q    <= '0;
      acc_q     <= '0;
      p00_q     <= ykf_pkg::OneV;
      p01_q     <= '0;
      p11_q     <= ykf_pkg::OneV;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          ykf_pkg::RegProc:  qv_q <= cfg_wdata_i;
          ykf_pkg::RegWheel: r1_q <= cfg_wdata_i;
          ykf_pkg::RegGyro:  r2_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (!s_axis_tuser) begin
          pc_q <= ykf_pkg::PcPredict;
        end else if (started_q) begin
          pc_q <= ykf_pkg::PcUpdate;
        end else begin
          pc_q      <= ykf_pkg::PcInit;
          started_q <= 1'b1;
        end
      end else if (st_q == ykf_pkg::ST_WB) begin
        pc_q <= pc_q + 1'b1;
      end
      if (wb_en) begin
        unique case (uop.dst)
          ykf_pkg::S_RATE: rate_q <= wb_val;
          ykf_pkg::S_ACC:  acc_q  <= wb_val;
          ykf_pkg::S_P00:  p00_q  <= wb_val;
          ykf_pkg::S_P01:  p01_q  <= wb_val;
          ykf_pkg::S_P11:  p11_q  <= wb_val;
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q <= W'(s_axis_tdata[15:0]);
      zw_q <= s_axis_tdata[47:16];
      zg_q <= s_axis_tdata[79:48];
    end
    if (st_q == ykf_pkg::ST_EXEC) begin
      unique case (uop.op)
        ykf_pkg::OP_ADD:  res_q <= sat33(sum);
        ykf_pkg::OP_SUB:  res_q <= sat33(dif);
        ykf_pkg::OP_MEAN: res_q <= msum[W-1:0];
        default: ;
      endcase
    end else if (st_q == ykf_pkg::ST_DIVW && div_done) begin
      res_q <= div_res;
    end
    if (out_load) begin
      m_data_q <= {started_q,
                   p00_q[W-1] ? {ykf_pkg::RegW{1'b0}} : p00_q[ykf_pkg::RegW-1:0],
                   acc_q, rate_q};
    end
  end

  // scratch values
  always_ff @(posedge clk_i) begin
    if (wb_en && uop.dst <= ykf_pkg::S_T10) begin
      tmp_mem[uop.dst[ykf_pkg::TmpAw-1:0]] <= wb_val;
    end
    if (st_q == ykf_pkg::ST_READ) begin
      rd_a_q <= tmp_mem[uop.a[ykf_pkg::TmpAw-1:0]];
      rd_b_q <= tmp_mem[uop.b[ykf_pkg::TmpAw-1:0]];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_CLK(a_started_sticky, started_q |=> started_q)
  `ASSERT_CLK(a_div_only_from_exec, div_start |=> (st_q == ykf_pkg::ST_DIVW))
  `ASSERT_CLK(a_accept_leaves_idle, accept |=> (st_q != ykf_pkg::ST_IDLE))
  `ASSERT_NEVER(a_load_over_pending, out_load && m_valid_q && !m_axis_tready)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] REG_PROC  = ykf_pkg::RegProc;
  localparam logic [1:0] REG_WHEEL = ykf_pkg::RegWheel;
  localparam logic [1:0] REG_GYRO  = ykf_pkg::RegGyro;
  localparam logic [1:0] REG_NONE  = 2'd3;
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic        ready;
    logic [30:0] var_rr;
    logic [31:0] accel;
    logic [31:0] rate;
  } yaw_res_t;

  int fails;

  task automatic report_mismatch(string what);
    fails++;
    $display("mismatch: %s at %0t", what, $realtime);
  endtask

  class yaw_scoreboard;
    yaw_res_t pending[$];
    longint q_var, r1_var, r2_var;
    longint rate_s, acc_s, p00, p01, p11;
    bit started;

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sadd(longint a, longint b);
      return sat(a + b);
    endfunction

    function longint mulq(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0] m;
      bit neg;
      p = 128'(a) * 128'(b);
      neg = p < 0;
      m = neg ? -p : p;
      m = (m + 128'd32768) >> 16;
      if (neg) return (m > 128'd2147483648) ? -64'sd2147483648 : -longint'(m);
      return (m > 128'd2147483647) ? 64'sd2147483647 : longint'(m);
    endfunction

    function longint divq(longint num, longint den);
      logic [127:0] m, qq, rr;
      bit neg;
      neg = num < 0;
      m = neg ? -num : num;
      m = m << 16;
      qq = m / den;
      rr = m % den;
      if (rr >= den - rr) qq = qq + 1;
      if (neg) return (qq > 128'd2147483648) ? -64'sd2147483648 : -longint'(qq);
      return (qq > 128'd2147483647) ? 64'sd2147483647 : longint'(qq);
    endfunction

    function void reset_state();
      q_var = 65536; r1_var = 65536; r2_var = 65536;
      rate_s = 0; acc_s = 0; p00 = 65536; p01 = 0; p11 = 65536;
      started = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] v);
      case (idx)
        REG_PROC:  q_var = v;
        REG_WHEEL: r1_var = v;
        REG_GYRO:  r2_var = v;
        default: ;
      endcase
    endfunction

    function void predict(longint dt);
      longint dt2, h, t, a, b, c;
      a = p00; b = p01; c = p11;
      dt2 = mulq(dt, dt);
      h = mulq(dt2, 32768);
      rate_s = sadd(rate_s, mulq(dt, acc_s));
      t = mulq(dt, b);
      p00 = sadd(sadd(sadd(sadd(a, t), t), mulq(dt2, c)), mulq(mulq(h, h), q_var));
      p01 = sadd(sadd(b, mulq(dt, c)), mulq(mulq(h, dt), q_var));
      p11 = sadd(c, mulq(dt2, q_var));
    endfunction

    function void fuse(longint zw, longint zg);
      longint a, b, c, det, q1, q2, k00, k01, k10, k11, y1, y2, al, be, oma, t;
      a = p00; b = p01; c = p11;
      det = sadd(mulq(a, sadd(r1_var, r2_var)), mulq(r1_var, r2_var));
      if (det <= 0) return;
      q1 = divq(r1_var, det);
      q2 = divq(r2_var, det);
      k00 = mulq(a, q2); k01 = mulq(a, q1);
      k10 = mulq(b, q2); k11 = mulq(b, q1);
      y1 = sat(zw - rate_s);
      y2 = sat(zg - rate_s);
      rate_s = sadd(sadd(rate_s, mulq(k00, y1)), mulq(k01, y2));
      acc_s = sadd(sadd(acc_s, mulq(k10, y1)), mulq(k11, y2));
      al = sadd(k00, k01);
      be = sadd(k10, k11);
      oma = sat(65536 - al);
      p00 = sadd(sadd(mulq(mulq(oma, oma), a), mulq(mulq(k00, k00), r1_var)),
                 mulq(mulq(k01, k01), r2_var));
      p01 = sadd(sadd(mulq(oma, sat(b - mulq(be, a))), mulq(mulq(k00, k10), r1_var)),
                 mulq(mulq(k01, k11), r2_var));
      t = mulq(be, b);
      p11 = sadd(sadd(sadd(sat(sat(mulq(mulq(be, be), a) - t) - t), c),
                      mulq(mulq(k10, k10), r1_var)), mulq(mulq(k11, k11), r2_var));
    endfunction

    function void note_request(logic act, logic [15:0] ts, logic [31:0] wr, logic [31:0] gr);
      yaw_res_t e;
      longint s, w, g;
      w = longint'(signed'(wr));
      g = longint'(signed'(gr));
      if (act == ACT_PREDICT) begin
        if (started) predict(longint'(ts));
      end else if (!started) begin
        s = w + g;
        rate_s = (s >= 0) ? s / 2 : -((1 - s) / 2);
        acc_s = 0; p00 = 65536; p01 = 0; p11 = 10 * 65536;
        started = 1;
      end else begin
        fuse(w, g);
      end
      e.rate = rate_s[31:0];
      e.accel = acc_s[31:0];
      e.var_rr = (p00 < 0) ? 31'd0 : p00[30:0];
      e.ready = started;
      pending.push_back(e);
    endfunction

    task check_result(yaw_res_t got);
      yaw_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      e = pending.pop_front();
      if (got.rate !== e.rate) report_mismatch("rate_estimate");
      if (got.accel !== e.accel) report_mismatch("accel_estimate");
      if (got.var_rr !== e.var_rr) report_mismatch("rate_variance");
      if (got.ready !== e.ready) report_mismatch("ready_res");
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [30:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;

  yaw_scoreboard sb;
  int idle_cycles;
  bit hold_off;
  bit quiet_rx;

  yaw_rate_kalman_fusion_unit i_dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                      s_axis_tdata[79:48]);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni
        || cfg_we_i || (sb.pending.size() == 0 && !s_axis_tvalid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int n;
    m_axis_tready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 0;
        for (n = 0; n < 3000; n++) @(negedge clk_i);
        hold_off = 0;
      end
      if (quiet_rx) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    int n;
    while (sb.pending.size() != 0) @(negedge clk_i);
    for (n = 0; n < 400; n++) @(negedge clk_i);
  endtask

  task automatic send(logic act, logic [15:0] ts, logic [31:0] wr, logic [31:0] gr);
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= {gr, wr, ts};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [30:0] rand_var();
    case ($urandom_range(0, 4))
      0: return 31'h7fffffff;
      1: return 31'd0;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 4 * 65536));
    endcase
  endfunction

  task automatic send_burst(int cnt);
    int k;
    for (k = 0; k < cnt; k++) begin
      if ($urandom_range(0, 3) == 0)
        send(ACT_UPDATE, 16'($urandom), rand_rate(), rand_rate());
      else
        send(ACT_PREDICT, rand_dt(), $urandom, $urandom);
    end
    s_axis_tvalid <= 0;
  endtask

  initial begin
    int ph, sent, g, b;
    sb = new();
    sb.reset_state();
    fails = 0;
    idle_cycles = 0;
    hold_off = 0;
    quiet_rx = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_addr_i = REG_PROC;
    cfg_wdata_i = '0;
    s_axis_tvalid = 0;
    s_axis_tuser = ACT_PREDICT;
    s_axis_tdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: predicts before start, first update, extremes
    send(ACT_PREDICT, 16'hffff, 32'h7fffffff, 32'h80000000);
    send(ACT_UPDATE, 16'd0, 32'h7fffffff, 32'h7fffffff);
    send(ACT_PREDICT, 16'hffff, '0, '0);
    send(ACT_UPDATE, 16'hffff, 32'h80000000, 32'h80000000);
    send(ACT_PREDICT, 16'd0, '0, '0);
    send(ACT_PREDICT, 16'd1, '0, '0);
    send(ACT_UPDATE, 16'd0, 32'h00010000, 32'hffff0000);
    send(ACT_UPDATE, 16'd0, 32'h80000000, 32'h7fffffff);
    s_axis_tvalid <= 0;
    drain();
    write_cfg(REG_WHEEL, 31'd0);
    write_cfg(REG_GYRO, 31'd0);
    write_cfg(REG_NONE, 31'h7fffffff);
    send(ACT_PREDICT, 16'd100, '0, '0);
    send(ACT_UPDATE, 16'd0, 32'h00020000, 32'h00030000);
    s_axis_tvalid <= 0;
    drain();
    write_cfg(REG_PROC, 31'h7fffffff);
    write_cfg(REG_WHEEL, 31'h7fffffff);
    write_cfg(REG_GYRO, 31'h7fffffff);
    send(ACT_PREDICT, 16'hffff, '0, '0);
    send(ACT_UPDATE, 16'd0, 32'h7fffffff, 32'h80000000);
    send(ACT_PREDICT, 16'h8000, '0, '0);
    s_axis_tvalid <= 0;
    drain();

    // long receiver hold-off while requests keep coming
    hold_off = 1;
    send_burst(10);
    drain();

    sent = 0;
    ph = 0;
    while (sent < 1550) begin
      if (ph % 4 == 0) begin
        drain();
        write_cfg(REG_PROC, rand_var());
        write_cfg(REG_WHEEL, rand_var());
        write_cfg(REG_GYRO, rand_var());
      end
      quiet_rx = ($urandom_range(0, 5) == 0);
      b = $urandom_range(1, 20);
      send_burst(b);
      sent += b;
      g = $urandom_range(0, 60);
      repeat (g) @(negedge clk_i);
      ph++;
    end
    drain();
    if (fails == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ykf_pkg.sv
src/ykf_mul.sv
src/ykf_div.sv
src/yaw_rate_kalman_fusion_unit.sv
bench/tb_top.sv
